// File: hdl/gray_contrast_stretch_unit_defines.svh
// ----------------------------------------------------------------------------
// gray contrast stretch assertion macros
// shared concurrent check wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef GRAY_CONTRAST_STRETCH_UNIT_DEFINES_SVH
`define GRAY_CONTRAST_STRETCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define GCS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition that must hold in the cycle after the trigger
`define GCS_ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) else $error(msg);
`else
`define GCS_ASSERT(lbl, clk, rstn, prop, msg)
`define GCS_ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg)
`endif

`endif

// File: hdl/gcs_pkg.sv
// ----------------------------------------------------------------------------
// gcs_pkg
// types and constants shared by the contrast stretch modules
// ----------------------------------------------------------------------------
package gcs_pkg;

  localparam int PIX_W       = 8;
  localparam int PIXEL_MAX   = 255;
  localparam int PMAX_W      = $clog2(PIXEL_MAX + 1);
  localparam int NUM_W       = PIX_W + PMAX_W;   // (pixel - darkest) * PIXEL_MAX
  localparam int HI_W        = NUM_W - PIX_W;    // dividend bits above the quotient
  localparam int QUO_W       = 8;
  localparam int CNT_W       = $clog2(QUO_W + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [QUO_W-1:0] STRETCH_MAX =
      (PIXEL_MAX < 255) ? QUO_W'(PIXEL_MAX) : QUO_W'(255);

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_MAP     = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
    logic             frame_last;
  } in_t;

  typedef struct packed {
    logic [QUO_W-1:0] stretched;
    logic             last_out;
  } out_t;

  // one division job handed from the front to the back
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [PIX_W-1:0] span;
    logic             zero;
    logic             last;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

// File: hdl/gcs_front.sv
// ----------------------------------------------------------------------------
// gcs_front
// takes input transactions, keeps the frame min/max, builds division jobs
// ----------------------------------------------------------------------------
module gcs_front import gcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  in_t     in_data_i,
  input  q_stat_t q_stat_i,
  output logic    push_o,
  output job_t    job_o
);

  logic [PIX_W-1:0] darkest_q, darkest_d;
  logic [PIX_W-1:0] brightest_q, brightest_d;
  logic             accept;
  logic [PIX_W-1:0] diff;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    darkest_d   = darkest_q;
    brightest_d = brightest_q;
    if (accept && in_data_i.operation == OP_MEASURE) begin
      if (in_data_i.frame_start) begin
        darkest_d   = in_data_i.pixel;
        brightest_d = in_data_i.pixel;
      end else begin
        if (in_data_i.pixel < darkest_q) darkest_d = in_data_i.pixel;
        if (in_data_i.pixel > brightest_q) brightest_d = in_data_i.pixel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      darkest_q   <= '1;
      brightest_q <= '0;
    end else begin
      darkest_q   <= darkest_d;
      brightest_q <= brightest_d;
    end
  end

  // map job uses the statistics as they stand when the pixel arrives
  assign diff       = in_data_i.pixel - darkest_q;
  assign push_o     = accept && in_data_i.operation == OP_MAP;
  assign job_o.num  = NUM_W'(diff) * NUM_W'(PIXEL_MAX);
  assign job_o.span = brightest_q - darkest_q;
  assign job_o.zero = (brightest_q <= darkest_q) || (in_data_i.pixel <= darkest_q);
  assign job_o.last = in_data_i.frame_last;

endmodule

// File: hdl/gcs_queue.sv
// ----------------------------------------------------------------------------
// gcs_queue
// short job queue between the front and the divider
// ----------------------------------------------------------------------------
`include "gray_contrast_stretch_unit_defines.svh"

module gcs_queue import gcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    job_o,
  output q_stat_t stat_o
);

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign stat_o.not_empty = (count_q != '0);
  assign stat_o.full      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign job_o            = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= job_i;
  end

  `GCS_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && stat_o.full), "push into full queue")
  `GCS_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && !stat_o.not_empty), "pop from empty queue")

endmodule

// File: hdl/gcs_back.sv
// ----------------------------------------------------------------------------
// gcs_back
// restoring divider, one quotient bit per cycle unless held; result register
// ----------------------------------------------------------------------------
`include "gray_contrast_stretch_unit_defines.svh"

module gcs_back import gcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t q_stat_i,
  input  job_t    job_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output out_t    out_data_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam int   CMP_W   = HI_W + PIX_W;

  logic             state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PIX_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] dvd_q, dvd_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [PIX_W-1:0] span_q;
  logic             zero_q, sat_q, last_q;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [HI_W-1:0]  num_hi;
  logic             sat_c;
  logic [PIX_W:0]   trial;
  logic             ge;
  logic             out_free;
  logic             advance;
  logic             res_we;
  logic [QUO_W-1:0] quo_fin;

  assign num_hi   = job_i.num[NUM_W-1:PIX_W];
  // quotient would need more than eight bits
  assign sat_c    = CMP_W'(num_hi) >= CMP_W'(job_i.span);
  assign trial    = {rem_q, dvd_q[QUO_W-1]};
  assign ge       = trial >= {1'b0, span_q};
  assign out_free = !out_valid_q || out_ready_i;
  // the last step waits until the result register can take it
  assign advance  = (state_q == ST_RUN) && ((cnt_q != CNT_W'(1)) || out_free);
  assign res_we   = advance && (cnt_q == CNT_W'(1));
  assign quo_fin  = {quo_q[QUO_W-2:0], ge};
  assign pop_o    = (state_q == ST_IDLE) && q_stat_i.not_empty;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_stat_i.not_empty) begin
          state_d = ST_RUN;
          cnt_d   = CNT_W'(QUO_W);
          rem_d   = sat_c ? '0 : PIX_W'(num_hi);
          dvd_d   = job_i.num[PIX_W-1:0];
          quo_d   = '0;
        end
      end
      ST_RUN: begin
        if (advance) begin
          rem_d = ge ? PIX_W'(trial - {1'b0, span_q}) : trial[PIX_W-1:0];
          dvd_d = {dvd_q[QUO_W-2:0], 1'b0};
          quo_d = quo_fin;
          cnt_d = cnt_q - 1'b1;
          if (res_we) begin
            state_d        = ST_IDLE;
            out_valid_d    = 1'b1;
            out_d.last_out = last_q;
            if (zero_q) out_d.stretched = '0;
            else if (sat_q || quo_fin > STRETCH_MAX) out_d.stretched = STRETCH_MAX;
            else out_d.stretched = quo_fin;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    out_q <= out_d;
    if (pop_o) begin
      span_q <= job_i.span;
      zero_q <= job_i.zero;
      sat_q  <= sat_c;
      last_q <= job_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GCS_ASSERT(a_run_cnt, clk_i, rst_ni, (state_q != ST_RUN) || (cnt_q != '0), "divider running with zero count")
  `GCS_ASSERT(a_no_clobber, clk_i, rst_ni, !res_we || out_free, "result overwrites pending output")
  `GCS_ASSERT_NEXT(a_pop_runs, clk_i, rst_ni, pop_o, (state_q == ST_RUN) && (cnt_q == CNT_W'(QUO_W)), "job popped but divider not started")

endmodule

// File: hdl/gray_contrast_stretch_unit.sv
// map pixel: restoring divider takes a job from the queue only when idle, loads it,
//   then one quotient bit per cycle; the last bit waits for a free result register
// measure pixel: one per cycle while the queue is not full, no result; a two-entry
//   job queue lets measuring continue while the divider works
// reset (rst_ni, async low): darkest 255, brightest 0, queue and output empty
// ----------------------------------------------------------------------------
// gray_contrast_stretch_unit
// min/max contrast stretch of 8-bit gray levels, measure and map passes
// ----------------------------------------------------------------------------
module gray_contrast_stretch_unit import gcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  job_t    job_in;
  job_t    job_out;

  gcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (job_in)
  );

  gcs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (q_stat)
  );

  gcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: verif/tb_gray_contrast_stretch_unit.sv
// ----------------------------------------------------------------------------
// tb_gray_contrast_stretch_unit
// checks measure and map passes of the contrast stretch against an in-order
// model of the running darkest/brightest levels and the rescale of each pixel
// ----------------------------------------------------------------------------
module tb_gray_contrast_stretch_unit import gcs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1200;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 300;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  // model of the statistics, updated at each accepted measure transaction
  logic [PIX_W-1:0] darkest_lvl   = 8'd255;
  logic [PIX_W-1:0] brightest_lvl = 8'd0;
  out_t             stretch_q[$];

  int  fail_count  = 0;
  int  idle_cycles = 0;
  int  burst_left  = 0;
  bit  hold_req    = 1'b0;

  gray_contrast_stretch_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic out_t stretch_pixel(in_t item);
    int unsigned span;
    int unsigned quo;
    out_t        res;
    res.last_out = item.frame_last;
    if (brightest_lvl <= darkest_lvl || item.pixel <= darkest_lvl) begin
      quo = 0;
    end else begin
      span = int'(brightest_lvl) - int'(darkest_lvl);
      quo  = (int'(item.pixel) - int'(darkest_lvl)) * PIXEL_MAX / span;
      if (quo > PIXEL_MAX) quo = PIXEL_MAX;
      if (quo > 255) quo = 255;
    end
    res.stretched = quo[QUO_W-1:0];
    return res;
  endfunction

  function automatic void measure_pixel(in_t item);
    if (item.frame_start) begin
      darkest_lvl   = item.pixel;
      brightest_lvl = item.pixel;
    end else begin
      if (item.pixel < darkest_lvl) darkest_lvl = item.pixel;
      if (item.pixel > brightest_lvl) brightest_lvl = item.pixel;
    end
  endfunction

  // output check first, then the input transaction of the same edge
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (stretch_q.size() == 0) begin
          $error("unexpected result stretched=%0d last_out=%0b",
                 out_data_o.stretched, out_data_o.last_out);
          fail_count++;
        end else begin
          want = stretch_q.pop_front();
          if (out_data_o.stretched !== want.stretched) begin
            $error("stretched: expected %0d, got %0d", want.stretched,
                   out_data_o.stretched);
            fail_count++;
          end
          if (out_data_o.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out,
                   out_data_o.last_out);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (in_data_i.operation == OP_MAP) stretch_q.push_back(stretch_pixel(in_data_i));
        else measure_pixel(in_data_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // receiver: stall pattern in segments, plus one long hold on request
  initial begin
    int seg_left;
    int stall_mode;
    seg_left   = 0;
    stall_mode = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        seg_left   = $urandom_range(20, 200);
      end
      seg_left--;
      case (stall_mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = 1'($urandom_range(0, 1));
        2: out_ready_i = ($urandom_range(0, 3) == 0);
        default: out_ready_i = ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // called and returns at a falling edge
  task automatic send_pixel(input logic op, input logic [PIX_W-1:0] pix,
                            input logic start, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 30);
    end
    in_valid_i            = 1'b1;
    in_data_i.operation   = op;
    in_data_i.pixel       = pix;
    in_data_i.frame_start = start;
    in_data_i.frame_last  = last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_measure_frame(input int lo, input int hi, input int n);
    for (int i = 0; i < n; i++) begin
      send_pixel(OP_MEASURE, PIX_W'($urandom_range(lo, hi)), i == 0, i == n - 1);
    end
  endtask

  task automatic test_no_statistics();
    // nothing measured since reset: every map gives zero
    send_pixel(OP_MAP, 8'd0, 1'b0, 1'b0);
    send_pixel(OP_MAP, 8'd128, 1'b0, 1'b0);
    send_pixel(OP_MAP, 8'd255, 1'b1, 1'b1);
    // measuring without a start after reset still finds min and max
    send_pixel(OP_MEASURE, 8'd40, 1'b0, 1'b0);
    send_pixel(OP_MEASURE, 8'd200, 1'b0, 1'b1);
    send_pixel(OP_MAP, 8'd120, 1'b0, 1'b1);
  endtask

  task automatic test_directed_cases();
    // full range, start ignored on map
    send_pixel(OP_MEASURE, 8'd255, 1'b1, 1'b0);
    send_pixel(OP_MEASURE, 8'd0, 1'b0, 1'b1);
    send_pixel(OP_MAP, 8'd0, 1'b1, 1'b0);
    send_pixel(OP_MAP, 8'd255, 1'b0, 1'b0);
    send_pixel(OP_MAP, 8'd127, 1'b0, 1'b1);
    // flat frame
    send_pixel(OP_MEASURE, 8'd100, 1'b1, 1'b1);
    send_pixel(OP_MAP, 8'd100, 1'b0, 1'b0);
    send_pixel(OP_MAP, 8'd99, 1'b0, 1'b0);
    send_pixel(OP_MAP, 8'd101, 1'b0, 1'b1);
    // pixels outside the measured range saturate
    send_pixel(OP_MEASURE, 8'd50, 1'b1, 1'b0);
    send_pixel(OP_MEASURE, 8'd150, 1'b0, 1'b1);
    send_pixel(OP_MAP, 8'd10, 1'b0, 1'b0);
    send_pixel(OP_MAP, 8'd200, 1'b0, 1'b0);
    send_pixel(OP_MAP, 8'd149, 1'b0, 1'b0);
    send_pixel(OP_MAP, 8'd51, 1'b0, 1'b1);
    // span of one
    send_pixel(OP_MEASURE, 8'd254, 1'b1, 1'b0);
    send_pixel(OP_MEASURE, 8'd255, 1'b0, 1'b1);
    send_pixel(OP_MAP, 8'd255, 1'b0, 1'b1);
  endtask

  task automatic test_random_frames();
    int sent;
    int lo;
    int hi;
    int n;
    int m;
    logic [PIX_W-1:0] pix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_pixel(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        lo = $urandom_range(0, 255);
        hi = ($urandom_range(0, 9) == 0) ? lo : $urandom_range(lo, 255);
        n  = $urandom_range(1, 12);
        if ($urandom_range(0, 7) == 0) begin
          // broken frame: no start flag, statistics keep accumulating
          for (int i = 0; i < n; i++) begin
            send_pixel(OP_MEASURE, PIX_W'($urandom_range(lo, hi)), 1'b0,
                       1'($urandom_range(0, 1)));
          end
        end else begin
          send_measure_frame(lo, hi, n);
        end
        m = $urandom_range(1, 12);
        for (int i = 0; i < m; i++) begin
          pix = ($urandom_range(0, 3) != 0) ? PIX_W'($urandom_range(lo, hi))
                                            : PIX_W'($urandom_range(0, 255));
          send_pixel(OP_MAP, pix, 1'($urandom_range(0, 1)), i == m - 1);
        end
        sent += n + m;
      end
    end
  endtask

  task automatic test_output_backpressure();
    // receiver holds off while the sender keeps offering
    burst_left = 1000;
    hold_req   = 1'b1;
    send_measure_frame(20, 220, 4);
    for (int i = 0; i < 16; i++) begin
      send_pixel(OP_MAP, PIX_W'($urandom_range(0, 255)), 1'b0, i == 15);
    end
    burst_left = 0;
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_no_statistics();
    test_directed_cases();
    test_output_backpressure();
    test_random_frames();
    in_valid_i = 1'b0;
    wait (stretch_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
